// ===== rtl/core/nfba_pkg.sv =====
`timescale 1ns / 1ps
// nfba_pkg: shared constants for the next-fit block allocator
// no dependencies

package nfba_pkg;

  localparam int unsigned OP_W    = 1;
  localparam int unsigned UNITS_W = 12;
  localparam int unsigned SPLIT_HEADERS = 3;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_NOFIT = 1'b1;

endpackage

// ===== rtl/core/nfba_req_if.sv =====
`timescale 1ns / 1ps
// nfba_req_if: request channel of the allocator
// depends on nfba_pkg

interface nfba_req_if import nfba_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    operation;
  logic [UNITS_W-1:0] request_units;
  logic [UNITS_W-1:0] release_offset;

  modport source (output valid, operation, request_units, release_offset, input ready);
  modport sink (input valid, operation, request_units, release_offset, output ready);
endinterface

// ===== rtl/core/nfba_rsp_if.sv =====
`timescale 1ns / 1ps
// nfba_rsp_if: response channel of the allocator
// depends on nfba_pkg

interface nfba_rsp_if import nfba_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [UNITS_W-1:0] object_offset;
  logic               status;

  modport source (output valid, object_offset, status, input ready);
  modport sink (input valid, object_offset, status, output ready);
endinterface

// ===== rtl/core/nfba_ram.sv =====
`timescale 1ns / 1ps
// nfba_ram: generic single write, single read ram with registered read
// no dependencies

module nfba_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/core/nfba_hdr_store.sv =====
`timescale 1ns / 1ps
// nfba_hdr_store: block header memory, entry zero reads as the initial free block
// depends on nfba_ram

module nfba_hdr_store #(
  parameter int unsigned CHUNK_UNITS  = 4096,
  parameter int unsigned HEADER_UNITS = 1
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           we,
  input  logic [$clog2(CHUNK_UNITS)-1:0] waddr,
  input  logic [$clog2(CHUNK_UNITS):0]   wdata,
  input  logic [$clog2(CHUNK_UNITS)-1:0] raddr,
  output logic [$clog2(CHUNK_UNITS):0]   rdata
);
  localparam int unsigned AW = $clog2(CHUNK_UNITS);
  localparam logic [AW:0] INIT_HDR = {1'b1, AW'(CHUNK_UNITS - HEADER_UNITS)};

  logic          init0;
  logic          rd_init;
  logic [AW:0]   ram_q;

  nfba_ram #(.WIDTH(AW + 1), .DEPTH(CHUNK_UNITS)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(ram_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      init0   <= 1'b1;
      rd_init <= 1'b0;
    end else begin
      if (we && waddr == '0) begin
        init0 <= 1'b0;
      end
      rd_init <= init0 && raddr == '0;
    end
  end

  assign rdata = rd_init ? INIT_HDR : ram_q;
endmodule

// ===== rtl/core/next_fit_block_allocator.sv =====
`timescale 1ns / 1ps
// next_fit_block_allocator: next-fit allocator with coalescing of following free blocks
// steps: a header walked takes S_ACHK and S_AHDR, a header merged S_MCHK and S_MHDR,
// a free block tested also S_MDONE, a split S_SPLIT and a wrap of the search an S_ACHK step
// throughput: one word at a time, a new request is taken once the response is delivered
// the response word follows the last step; the header memory read port sets the pace
// reset: synchronous, the chunk becomes one free block and the search point returns to zero
// depends on nfba_pkg, nfba_req_if, nfba_rsp_if, nfba_hdr_store

module next_fit_block_allocator import nfba_pkg::*; #(
  parameter int unsigned CHUNK_UNITS  = 4096,
  parameter int unsigned HEADER_UNITS = 1
) (
  input logic       clk,
  input logic       rst,
  nfba_req_if.sink  req,
  nfba_rsp_if.source rsp
);
  localparam int unsigned AW = $clog2(CHUNK_UNITS);
  localparam int unsigned PW = AW + 1;
  localparam int unsigned CW = ((AW > UNITS_W) ? AW : UNITS_W) + 3;
  localparam logic [PW-1:0] HP    = PW'(HEADER_UNITS);
  localparam logic [PW-1:0] CHUNK = PW'(CHUNK_UNITS);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_ACHK  = 4'd1;
  localparam logic [3:0] S_AHDR  = 4'd2;
  localparam logic [3:0] S_MCHK  = 4'd3;
  localparam logic [3:0] S_MHDR  = 4'd4;
  localparam logic [3:0] S_MDONE = 4'd5;
  localparam logic [3:0] S_SPLIT = 4'd6;
  localparam logic [3:0] S_FCHK  = 4'd7;
  localparam logic [3:0] S_FHDR  = 4'd8;
  localparam logic [3:0] S_FTGT  = 4'd9;

  logic [3:0]         state;
  logic [PW-1:0]      at, m, first, start, to, target, nfp;
  logic               pass, op;
  logic [UNITS_W-1:0] rq;
  logic [PW-1:0]      tail_at;
  logic [AW-1:0]      tail_size;
  logic               ov;
  logic [UNITS_W-1:0] out_off;
  logic               out_status;

  logic               we;
  logic [AW-1:0]      waddr, raddr;
  logic [AW:0]        wdata, rdata;
  logic               hfree;
  logic [PW-1:0]      hstep_at, hstep_m;
  logic [PW-1:0]      msize;
  logic [CW-1:0]      avail_c, req_c;
  logic               fits, split;

  nfba_hdr_store #(.CHUNK_UNITS(CHUNK_UNITS), .HEADER_UNITS(HEADER_UNITS)) u_hdr (
    .clk(clk), .rst(rst), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr(raddr), .rdata(rdata)
  );

  assign hfree    = rdata[AW];
  assign hstep_at = at + {1'b0, rdata[AW-1:0]} + HP;
  assign hstep_m  = m + {1'b0, rdata[AW-1:0]} + HP;
  assign msize    = m - first - HP;
  assign avail_c  = CW'(msize);
  assign req_c    = CW'(rq);
  assign fits     = op == OP_ALLOC && avail_c >= req_c;
  assign split    = avail_c > req_c + CW'(SPLIT_HEADERS * HEADER_UNITS);

  always_comb begin
    raddr = (state == S_MCHK) ? m[AW-1:0] : at[AW-1:0];
    we    = 1'b0;
    waddr = first[AW-1:0];
    wdata = {1'b1, msize[AW-1:0]};
    if (state == S_MDONE) begin
      we = 1'b1;
      if (fits) begin
        wdata = {1'b0, split ? req_c[AW-1:0] : msize[AW-1:0]};
      end
    end else if (state == S_SPLIT) begin
      we    = 1'b1;
      waddr = tail_at[AW-1:0];
      wdata = {1'b1, tail_size};
    end
  end

  assign req.ready         = state == S_IDLE && !ov;
  assign rsp.valid         = ov;
  assign rsp.object_offset = out_off;
  assign rsp.status        = out_status;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      nfp   <= '0;
      ov    <= 1'b0;
    end else begin
      if (ov && rsp.ready) begin
        ov <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req.valid && !ov) begin
            op         <= req.operation;
            rq         <= req.request_units;
            out_off    <= '0;
            out_status <= STATUS_OK;
            if (req.operation == OP_ALLOC) begin
              start <= nfp;
              at    <= nfp;
              to    <= CHUNK;
              pass  <= 1'b0;
              state <= S_ACHK;
            end else if (PW'(req.release_offset) >= HP) begin
              target <= PW'(req.release_offset) - HP;
              at     <= '0;
              state  <= S_FCHK;
            end else begin
              ov <= 1'b1;
            end
          end
        end
        S_ACHK: begin
          if (at < to && at < CHUNK) begin
            state <= S_AHDR;
          end else if (!pass) begin
            pass  <= 1'b1;
            at    <= '0;
            to    <= start;
          end else begin
            out_status <= STATUS_NOFIT;
            ov         <= 1'b1;
            state      <= S_IDLE;
          end
        end
        S_AHDR: begin
          if (hfree) begin
            first <= at;
            m     <= hstep_at;
            state <= S_MCHK;
          end else begin
            at    <= hstep_at;
            state <= S_ACHK;
          end
        end
        S_MCHK: begin
          state <= (m < CHUNK) ? S_MHDR : S_MDONE;
        end
        S_MHDR: begin
          if (hfree) begin
            m     <= hstep_m;
            state <= S_MCHK;
          end else begin
            state <= S_MDONE;
          end
        end
        S_MDONE: begin
          if (fits) begin
            nfp     <= first;
            out_off <= UNITS_W'(first + HP);
            if (split) begin
              tail_at   <= first + PW'(rq) + HP;
              tail_size <= AW'(avail_c - req_c - CW'(HEADER_UNITS));
              state     <= S_SPLIT;
            end else begin
              ov    <= 1'b1;
              state <= S_IDLE;
            end
          end else begin
            if (nfp > first && nfp < m) begin
              nfp <= first;
            end
            if (op == OP_ALLOC) begin
              at    <= m;
              state <= S_ACHK;
            end else begin
              ov    <= 1'b1;
              state <= S_IDLE;
            end
          end
        end
        S_SPLIT: begin
          ov    <= 1'b1;
          state <= S_IDLE;
        end
        S_FCHK: begin
          if (at < CHUNK && at < target) begin
            state <= S_FHDR;
          end else if (at == target && at < CHUNK) begin
            state <= S_FTGT;
          end else begin
            ov    <= 1'b1;
            state <= S_IDLE;
          end
        end
        S_FHDR: begin
          at    <= hstep_at;
          state <= S_FCHK;
        end
        S_FTGT: begin
          first <= at;
          m     <= hstep_at;
          state <= S_MCHK;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_nfp_in_chunk: assert property (@(posedge clk) disable iff (rst) nfp < CHUNK)
    else $error("search point outside chunk");
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    ov && out_status == STATUS_NOFIT |-> out_off == '0)
    else $error("failed allocation carries an offset");
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> state != S_IDLE || ov)
    else $error("request taken but no work started");
  a_write_states: assert property (@(posedge clk) disable iff (rst)
    we |-> state == S_MDONE || state == S_SPLIT)
    else $error("header write outside merge or split");
endmodule

// ===== tb/sv/nfba_checker.sv =====
`timescale 1ns / 1ps
// nfba_checker: watches the request and response channels of the allocator,
// predicts each response from its own heap image and compares
// depends on nfba_pkg, nfba_req_if, nfba_rsp_if

module nfba_checker import nfba_pkg::*; #(
  parameter int unsigned CHUNK_UNITS  = 4096,
  parameter int unsigned HEADER_UNITS = 1
) (
  input  logic clk,
  input  logic rst,
  nfba_req_if  req,
  nfba_rsp_if  rsp,
  output int   fail_count,
  output int   awaiting
);

  typedef struct packed {
    logic [UNITS_W-1:0] offset;
    logic               status;
  } alloc_result_t;

  int unsigned   blk_size [CHUNK_UNITS];
  bit            blk_free [CHUNK_UNITS];
  int unsigned   fit_point;
  alloc_result_t expected_q[$];

  initial begin
    fail_count = 0;
    awaiting   = 0;
  end

  function automatic void clear_heap();
    for (int i = 0; i < CHUNK_UNITS; i++) begin
      blk_size[i] = 0;
      blk_free[i] = 1'b0;
    end
    blk_size[0] = CHUNK_UNITS - HEADER_UNITS;
    blk_free[0] = 1'b1;
    fit_point = 0;
  endfunction

  function automatic void coalesce(int unsigned first);
    int unsigned at;
    at = first;
    do begin
      at += blk_size[at] + HEADER_UNITS;
    end while (at < CHUNK_UNITS && blk_free[at]);
    blk_size[first] = at - first - HEADER_UNITS;
    blk_free[first] = 1'b1;
    if (fit_point > first && fit_point < at) fit_point = first;
  endfunction

  function automatic bit search_fit(int unsigned want, int unsigned from, int unsigned to,
                                    output int unsigned pos);
    int unsigned at;
    int unsigned avail;
    at  = from;
    pos = 0;
    while (at < to && at < CHUNK_UNITS) begin
      if (blk_free[at]) begin
        coalesce(at);
        avail = blk_size[at];
        if (avail >= want) begin
          if (avail > want + HEADER_UNITS * SPLIT_HEADERS) begin
            blk_size[at + want + HEADER_UNITS] = avail - want - HEADER_UNITS;
            blk_free[at + want + HEADER_UNITS] = 1'b1;
            blk_size[at] = want;
          end
          blk_free[at] = 1'b0;
          fit_point = at;
          pos = at;
          return 1'b1;
        end
      end
      at += blk_size[at] + HEADER_UNITS;
    end
    return 1'b0;
  endfunction

  function automatic alloc_result_t predict_word(logic op, logic [UNITS_W-1:0] units,
                                                 logic [UNITS_W-1:0] rel);
    alloc_result_t r;
    int unsigned   start;
    int unsigned   pos;
    int unsigned   target;
    int unsigned   at;
    bit            ok;
    r.offset = '0;
    r.status = STATUS_OK;
    if (op == OP_ALLOC) begin
      start = fit_point;
      ok = search_fit(units, start, CHUNK_UNITS, pos);
      if (!ok) ok = search_fit(units, 0, start, pos);
      if (ok) r.offset = UNITS_W'(pos + HEADER_UNITS);
      else r.status = STATUS_NOFIT;
    end else if (rel >= HEADER_UNITS) begin
      target = rel - HEADER_UNITS;
      at = 0;
      while (at < CHUNK_UNITS && at < target) at += blk_size[at] + HEADER_UNITS;
      if (at == target && at < CHUNK_UNITS) begin
        blk_free[at] = 1'b1;
        coalesce(at);
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    fail_count++;
  endtask

  always @(posedge clk) begin
    alloc_result_t want;
    if (rst) begin
      clear_heap();
      expected_q.delete();
    end else begin
      if (req.valid && req.ready)
        expected_q.push_back(predict_word(req.operation, req.request_units,
                                          req.release_offset));
      if (rsp.valid && rsp.ready) begin
        if (expected_q.size() == 0) begin
          report_mismatch("response word with nothing expected");
        end else begin
          want = expected_q.pop_front();
          if (rsp.object_offset !== want.offset)
            report_mismatch($sformatf("object_offset %0d, expected %0d",
                                      rsp.object_offset, want.offset));
          if (rsp.status !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d", rsp.status, want.status));
        end
      end
    end
    awaiting <= expected_q.size();
  end

endmodule

// ===== tb/sv/tb_next_fit_block_allocator.sv =====
`timescale 1ns / 1ps
// tb_next_fit_block_allocator: drives requests into the allocator with random gaps
// and response stalls, and gives the verdict from the checker's failure and awaiting counts
// depends on nfba_pkg, nfba_req_if, nfba_rsp_if, nfba_checker, next_fit_block_allocator

module tb_next_fit_block_allocator;
  import nfba_pkg::*;

  logic clk;
  logic rst;
  int   fail_count;
  int   awaiting;
  bit   calm;
  int   stall_left;
  int   n_alloc, n_free, n_nofit;

  logic               sent_ops[$];
  logic [UNITS_W-1:0] live[$];
  logic [UNITS_W-1:0] released[$];

  nfba_req_if req ();
  nfba_rsp_if rsp ();

  next_fit_block_allocator u_top (.clk(clk), .rst(rst), .req(req.sink), .rsp(rsp.source));

  nfba_checker u_checker (
    .clk(clk), .rst(rst), .req(req), .rsp(rsp),
    .fail_count(fail_count), .awaiting(awaiting)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #100ms;
    $display("timeout");
    $display("tb_next_fit_block_allocator failed");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // response side: random stalls, some long
  always @(posedge clk) begin
    if (rst || calm) begin
      rsp.ready  <= 1'b1;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      rsp.ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 99) < 4) begin
      rsp.ready  <= 1'b0;
      stall_left <= $urandom_range(10, 80);
    end else begin
      rsp.ready <= ($urandom_range(0, 3) != 0);
    end
  end

  // track live offsets for the free side of the stimulus
  always @(posedge clk) begin
    logic op;
    if (!rst && req.valid && req.ready) sent_ops.push_back(req.operation);
    if (!rst && rsp.valid && rsp.ready && sent_ops.size() > 0) begin
      op = sent_ops.pop_front();
      if (op == OP_ALLOC) begin
        if (rsp.status == STATUS_OK) begin
          live.push_back(rsp.object_offset);
          n_alloc++;
        end else begin
          n_nofit++;
        end
      end
    end
  end

  task automatic send_word(logic op, logic [UNITS_W-1:0] units, logic [UNITS_W-1:0] rel);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.valid          <= 1'b1;
    req.operation      <= op;
    req.request_units  <= units;
    req.release_offset <= rel;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    if (op == OP_FREE) n_free++;
  endtask

  task automatic drain();
    req.valid <= 1'b0;
    @(posedge clk);
    while (awaiting != 0 || sent_ops.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic logic [UNITS_W-1:0] pick_units();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return UNITS_W'($urandom_range(1, 16));
    if (r < 85) return UNITS_W'($urandom_range(17, 256));
    if (r < 93) return '0;
    return UNITS_W'($urandom_range(257, 4095));
  endfunction

  task automatic send_free_word();
    int r;
    int idx;
    logic [UNITS_W-1:0] off;
    r = $urandom_range(0, 99);
    if (r < 80 && live.size() > 0) begin
      idx = $urandom_range(0, live.size() - 1);
      off = live[idx];
      live.delete(idx);
      released.push_back(off);
      if (released.size() > 32) void'(released.pop_front());
    end else if (r < 90 && released.size() > 0) begin
      off = released[$urandom_range(0, released.size() - 1)];
    end else begin
      off = UNITS_W'($urandom_range(0, 4095));
    end
    send_word(OP_FREE, '0, off);
  endtask

  initial begin
    int alloc_pct;
    calm = 1'b1;
    n_alloc = 0;
    n_free = 0;
    n_nofit = 0;
    rst <= 1'b1;
    req.valid          <= 1'b0;
    req.operation      <= OP_ALLOC;
    req.request_units  <= '0;
    req.release_offset <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: zero size, exact fit, no split at the edge, split, odd frees
    send_word(OP_ALLOC, 12'd0, '0);
    send_word(OP_ALLOC, 12'd1, '0);
    send_word(OP_ALLOC, 12'd2048, '0);
    send_word(OP_ALLOC, 12'd4095, '0);
    send_word(OP_FREE, '0, 12'd0);
    send_word(OP_FREE, '0, 12'd4095);
    send_word(OP_FREE, '0, 12'd3);
    send_word(OP_FREE, '0, 12'd2);
    send_word(OP_FREE, '0, 12'd2);
    send_word(OP_FREE, '0, 12'd4);
    send_word(OP_FREE, '0, 12'd1);
    send_word(OP_ALLOC, 12'd4095, '0);
    send_word(OP_FREE, '0, 12'd1);
    send_word(OP_ALLOC, 12'd4092, '0);
    send_word(OP_FREE, '0, 12'd1);
    send_word(OP_ALLOC, 12'd4091, '0);
    send_word(OP_ALLOC, 12'd4, '0);
    send_word(OP_FREE, '0, 12'd1);
    send_word(OP_ALLOC, 12'd8, '0);
    drain();
    live.delete();

    for (int phase = 0; phase < 10; phase++) begin
      calm = ($urandom_range(0, 3) == 0);
      alloc_pct = (phase % 2 == 0) ? 70 : 35;
      for (int i = 0; i < 103; i++) begin
        if (live.size() == 0) send_word(OP_ALLOC, pick_units(), UNITS_W'($urandom()));
        else if (live.size() >= 60) send_free_word();
        else if ($urandom_range(0, 99) < alloc_pct)
          send_word(OP_ALLOC, pick_units(), UNITS_W'($urandom()));
        else send_free_word();
      end
    end
    calm = 1'b0;
    drain();
    repeat (200) @(posedge clk);

    $display("covered %0d allocations, %0d no-fit answers, %0d free words",
             n_alloc, n_nofit, n_free);
    if (fail_count == 0 && awaiting == 0) begin
      $display("tb_next_fit_block_allocator passed");
    end else begin
      $display("tb_next_fit_block_allocator failed");
    end
    $finish;
  end

endmodule
